// ----- sv/bsev_pkg.sv -----
// Shared constants, types and fixed-point helpers for the Bezier surface evaluator.
package bsev_pkg;

  localparam int GRID_SIZE = 5;
  localparam int DEG       = GRID_SIZE - 1;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int K_W       = $clog2(GRID_SIZE + 1);
  localparam int CELL_W    = $clog2(CELLS);

  localparam int FRAC      = 16;
  localparam int Q_W       = 17;
  localparam int COORD_W   = 24;
  localparam int POS_W     = 3;
  localparam int BIN_W     = GRID_SIZE;
  localparam int BW_W      = Q_W + BIN_W;
  localparam int CW_W      = 2 * BW_W - FRAC;
  localparam int P_W       = COORD_W + CW_W + 1;
  localparam int ACC_W     = P_W + CELL_W;

  localparam int ONE       = 1 << FRAC;
  localparam int HALF      = 1 << (FRAC - 1);
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  localparam int INIT_N    = 5;
  localparam int INIT_W    = 3;
  localparam logic [7:0] INIT_HEIGHT [INIT_N][INIT_N] = '{
    '{8'd0,  8'd0,   8'd0,   8'd0,  8'd0},
    '{8'd0,  8'd60,  8'd70,  8'd40, 8'd10},
    '{8'd30, 8'd200, 8'd200, 8'd40, 8'd60},
    '{8'd30, 8'd70,  8'd40,  8'd50, 8'd60},
    '{8'd60, 8'd40,  8'd0,   8'd30, 8'd100}
  };

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WGT,
    S_SCAN,
    S_RES
  } seq_state_e;

  typedef enum logic [1:0] {
    W_IDLE,
    W_POW,
    W_BERN
  } wgt_state_e;

  // index 0 is x, 1 is y, 2 is z
  typedef logic [2:0][COORD_W-1:0] point_t;

  typedef logic [BIN_W-1:0] binom_tab_t [GRID_SIZE];

  typedef struct packed {
    logic clr;
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic   done;
    logic   sat;
    point_t pt;
  } mac_res_t;

  function automatic logic [Q_W-1:0] rnd_q(logic [Q_W-1:0] a, logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] p;
    p = (2*Q_W)'(a) * (2*Q_W)'(b) + (2*Q_W)'(HALF);
    return p[FRAC +: Q_W];
  endfunction

  function automatic binom_tab_t binom_row();
    int         tri_row [GRID_SIZE];
    binom_tab_t res;
    for (int i = 0; i < GRID_SIZE; i++) begin
      tri_row[i] = 0;
    end
    tri_row[0] = 1;
    for (int n = 1; n <= DEG; n++) begin
      for (int k = GRID_SIZE - 1; k > 0; k--) begin
        tri_row[k] = tri_row[k] + tri_row[k-1];
      end
    end
    for (int i = 0; i < GRID_SIZE; i++) begin
      res[i] = BIN_W'(tri_row[i]);
    end
    return res;
  endfunction

  function automatic point_t init_point(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    point_t p;
    p = '0;
    if (int'(r) < INIT_N && int'(c) < INIT_N) begin
      p[0] = COORD_W'(25 * int'(c) * 256);
      p[1] = COORD_W'((100 - 25 * int'(r)) * 256);
      p[2] = COORD_W'(int'(INIT_HEIGHT[INIT_W'(r)][INIT_W'(c)]) * 256);
    end
    return p;
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    return CELL_W'(int'(r) * GRID_SIZE + int'(c));
  endfunction

endpackage

// ----- sv/bsev_if.sv -----
// Request and result channel interfaces of the Bezier surface evaluator.
interface bsev_in_if import bsev_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [POS_W-1:0]          point_row;
  logic [POS_W-1:0]          point_col;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic [Q_W-1:0]            param_u;
  logic [Q_W-1:0]            param_v;

  modport source (
    output valid, operation, point_row, point_col, point_x, point_y, point_z,
           param_u, param_v,
    input  ready
  );

  modport sink (
    input  valid, operation, point_row, point_col, point_x, point_y, point_z,
           param_u, param_v,
    output ready
  );
endinterface

interface bsev_out_if import bsev_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] surf_x;
  logic signed [COORD_W-1:0] surf_y;
  logic signed [COORD_W-1:0] surf_z;
  logic                      saturated;

  modport source (
    output valid, surf_x, surf_y, surf_z, saturated,
    input  ready
  );

  modport sink (
    input  valid, surf_x, surf_y, surf_z, saturated,
    output ready
  );
endinterface

// ----- sv/bezier_surface_eval.sv -----
// Top level of the degree-4 tensor-product Bezier surface evaluator.
//
// Requests arrive on in_i (valid/ready). A write request (operation 0)
// stores one control point into the grid memory in the accept cycle and
// gives no result; a row or column outside the grid is dropped. An
// evaluate request (operation 1) returns one surface point on out_o.
// One request is in work at a time; in_i.ready is high while idle.
// An evaluation runs through the Bernstein weight units (power steps,
// then one weight per cycle plus a drain step), a handoff to the scan of
// the grid memory, which reads one control point per cycle into a
// shared multiply-accumulate, and the steps that multiply, accumulate,
// round and load the output register; the next request is taken after
// that load.
// The result sits in an output register; a new request is accepted while
// it waits, and a finished evaluation holds until that register is free.
// Reset returns the grid to its built-in points through per-entry valid
// bits (no clearing pass) and empties the output register.
module bezier_surface_eval import bsev_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  bsev_in_if.sink   in_i,
  bsev_out_if.source out_o
);

  seq_state_e        state_q, state_d;
  logic [IDX_W-1:0]  row_q, col_q;
  logic [CELL_W-1:0] cell_q;
  logic [CELLS-1:0]  ent_vld_q;
  logic              s1_vld_q, s1_first_q, s1_last_q, s1_ent_q;
  logic [IDX_W-1:0]  s1_row_q, s1_col_q;
  logic [CW_W-1:0]   cw_q;
  logic              out_vld_q;
  point_t            out_pt_q;
  logic              out_sat_q;

  logic              in_rdy, acc_in, is_eval, wr_ok, ram_we, start;
  logic              issue, last_cell, load_out, done_u, done_v;
  logic [CELL_W-1:0] waddr;
  point_t            wr_pt, rd_pt, coord;
  logic [BW_W-1:0]   wu, wv;
  logic [2*BW_W-1:0] cw_prod;
  mac_ctl_t          mac_ctl;
  mac_res_t          mac_res;

  assign acc_in    = in_i.valid && in_rdy;
  assign is_eval   = (in_i.operation == OP_EVAL);
  assign wr_ok     = (int'(in_i.point_row) < GRID_SIZE) && (int'(in_i.point_col) < GRID_SIZE);
  assign waddr     = cell_addr(in_i.point_row, in_i.point_col);
  assign last_cell = (cell_q == CELL_W'(CELLS - 1));

  always_comb begin
    wr_pt[0] = in_i.point_x;
    wr_pt[1] = in_i.point_y;
    wr_pt[2] = in_i.point_z;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (acc_in && is_eval) state_d = S_WGT;
      S_WGT:  if (done_u && done_v) state_d = S_SCAN;
      S_SCAN: if (last_cell) state_d = S_RES;
      S_RES:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_rdy   = (state_q == S_IDLE);
    ram_we   = acc_in && !is_eval && wr_ok;
    start    = acc_in && is_eval;
    issue    = (state_q == S_SCAN);
    load_out = (state_q == S_RES) && mac_res.done && (!out_vld_q || out_o.ready);
  end

  bsev_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (CELLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wr_pt),
    .raddr_i (cell_q),
    .rdata_o (rd_pt)
  );

  bsev_weights u_wgt_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .t_i     (in_i.param_u),
    .idx_i   (row_q),
    .done_o  (done_u),
    .w_o     (wu)
  );

  bsev_weights u_wgt_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .t_i     (in_i.param_v),
    .idx_i   (col_q),
    .done_o  (done_v),
    .w_o     (wv)
  );

  assign cw_prod = (2*BW_W)'(wu) * (2*BW_W)'(wv) + (2*BW_W)'(HALF);
  assign coord   = s1_ent_q ? rd_pt : init_point(s1_row_q, s1_col_q);

  always_comb begin
    mac_ctl.clr   = start;
    mac_ctl.vld   = s1_vld_q;
    mac_ctl.first = s1_first_q;
    mac_ctl.last  = s1_last_q;
  end

  bsev_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .pt_i   (coord),
    .cw_i   (cw_q),
    .res_o  (mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      row_q      <= '0;
      col_q      <= '0;
      cell_q     <= '0;
      ent_vld_q  <= '0;
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_vld_q   <= issue;
      s1_first_q <= issue && (cell_q == '0);
      s1_last_q  <= issue && last_cell;
      if (ram_we) begin
        ent_vld_q[waddr] <= 1'b1;
      end
      if (start) begin
        row_q  <= '0;
        col_q  <= '0;
        cell_q <= '0;
      end else if (issue) begin
        cell_q <= cell_q + CELL_W'(1);
        if (col_q == IDX_W'(GRID_SIZE - 1)) begin
          col_q <= '0;
          row_q <= row_q + IDX_W'(1);
        end else begin
          col_q <= col_q + IDX_W'(1);
        end
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cw_q     <= cw_prod[FRAC +: CW_W];
      s1_ent_q <= ent_vld_q[cell_q];
      s1_row_q <= row_q;
      s1_col_q <= col_q;
    end
    if (load_out) begin
      out_pt_q  <= mac_res.pt;
      out_sat_q <= mac_res.sat;
    end
  end

  assign in_i.ready      = in_rdy;
  assign out_o.valid     = out_vld_q;
  assign out_o.surf_x    = out_pt_q[0];
  assign out_o.surf_y    = out_pt_q[1];
  assign out_o.surf_z    = out_pt_q[2];
  assign out_o.saturated = out_sat_q;

  a_scan_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cell_q <= CELL_W'(CELLS - 1))
    else $error("grid scan ran past the last cell");

  a_out_from_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(mac_res.done))
    else $error("result loaded before accumulation finished");

  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !s1_vld_q && !mac_ctl.vld)
    else $error("grid write overlaps a grid scan");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> state_q == S_WGT && !mac_res.done && !done_u && !done_v)
    else $error("stale status after evaluate request");

endmodule

// ----- sv/bsev_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bsev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bsev_weights.sv -----
// Bernstein weight unit: powers of t and 1-t, then binomial-scaled weights.
module bsev_weights import bsev_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Q_W-1:0]   t_i,
  input  logic [IDX_W-1:0] idx_i,
  output logic             done_o,
  output logic [BW_W-1:0]  w_o
);

  localparam binom_tab_t BINOM = binom_row();

  wgt_state_e       state_q, state_d;
  logic [K_W-1:0]   k_q;
  logic             done_q;
  logic             pv_q;
  logic [Q_W-1:0]   tc_q, mc_q, pu_run_q, pw_run_q;
  logic [Q_W-1:0]   pu_q [GRID_SIZE];
  logic [Q_W-1:0]   pw_q [GRID_SIZE];
  logic [Q_W-1:0]   prod_q;
  logic [IDX_W-1:0] pk_q;
  logic [BW_W-1:0]  wt_q [GRID_SIZE];

  logic             pow_en, bern_en, finish;
  logic [IDX_W-1:0] kx;
  logic [Q_W-1:0]   tc_d, pu_nx, pw_nx;

  assign kx    = k_q[IDX_W-1:0];
  assign tc_d  = (t_i > Q_W'(ONE)) ? Q_W'(ONE) : t_i;
  assign pu_nx = rnd_q(pu_run_q, tc_q);
  assign pw_nx = rnd_q(pw_run_q, mc_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_IDLE: if (start_i) state_d = W_POW;
      W_POW:  if (k_q == K_W'(DEG)) state_d = W_BERN;
      W_BERN: if (k_q == K_W'(GRID_SIZE)) state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_comb begin
    pow_en  = (state_q == W_POW);
    bern_en = (state_q == W_BERN) && (k_q < K_W'(GRID_SIZE));
    finish  = (state_q == W_BERN) && (k_q == K_W'(GRID_SIZE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      k_q     <= '0;
      done_q  <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= bern_en;
      if (start_i) begin
        k_q    <= K_W'(1);
        done_q <= 1'b0;
      end else if (pow_en) begin
        k_q <= (k_q == K_W'(DEG)) ? '0 : k_q + K_W'(1);
      end else if (bern_en) begin
        k_q <= k_q + K_W'(1);
      end
      if (finish) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      tc_q     <= tc_d;
      mc_q     <= Q_W'(ONE) - tc_d;
      pu_run_q <= Q_W'(ONE);
      pw_run_q <= Q_W'(ONE);
      pu_q[0]  <= Q_W'(ONE);
      pw_q[0]  <= Q_W'(ONE);
    end
    if (pow_en) begin
      pu_q[kx] <= pu_nx;
      pw_q[kx] <= pw_nx;
      pu_run_q <= pu_nx;
      pw_run_q <= pw_nx;
    end
    if (bern_en) begin
      prod_q <= rnd_q(pu_q[kx], pw_q[IDX_W'(DEG) - kx]);
      pk_q   <= kx;
    end
    if (pv_q) begin
      wt_q[pk_q] <= BW_W'(BINOM[pk_q]) * BW_W'(prod_q);
    end
  end

  assign done_o = done_q;
  assign w_o    = wt_q[idx_i];

endmodule

// ----- sv/bsev_mac.sv -----
// Three-lane multiply-accumulate with final rounding and saturation.
module bsev_mac import bsev_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mac_ctl_t        ctl_i,
  input  point_t          pt_i,
  input  logic [CW_W-1:0] cw_i,
  output mac_res_t        res_o
);

  localparam logic signed [ACC_W-1:0] C_HI   = ACC_W'(COORD_MAX);
  localparam logic signed [ACC_W-1:0] C_LO   = ACC_W'(COORD_MIN);
  localparam logic signed [ACC_W-1:0] C_HALF = ACC_W'(HALF);

  logic                    mv_q, mf_q, ml_q, fin_q, done_q;
  logic signed [P_W-1:0]   mul_q [3];
  logic signed [P_W-1:0]   mul_d [3];
  logic signed [ACC_W-1:0] acc_q [3];
  logic signed [ACC_W-1:0] rq    [3];
  logic signed [ACC_W-1:0] rs    [3];
  logic [2:0]              clip;
  point_t                  rnd_pt;
  point_t                  res_pt_q;
  logic                    res_sat_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul_d[k] = P_W'(signed'(pt_i[k])) * P_W'(signed'({1'b0, cw_i}));
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rq[k] = acc_q[k] + C_HALF;
      rs[k] = rq[k] >>> FRAC;
      if (rs[k] > C_HI) begin
        rnd_pt[k] = C_HI[COORD_W-1:0];
        clip[k]   = 1'b1;
      end else if (rs[k] < C_LO) begin
        rnd_pt[k] = C_LO[COORD_W-1:0];
        clip[k]   = 1'b1;
      end else begin
        rnd_pt[k] = rs[k][COORD_W-1:0];
        clip[k]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q   <= 1'b0;
      mf_q   <= 1'b0;
      ml_q   <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mv_q  <= ctl_i.vld;
      mf_q  <= ctl_i.first;
      ml_q  <= ctl_i.last;
      fin_q <= mv_q && ml_q;
      if (ctl_i.clr) begin
        done_q <= 1'b0;
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      for (int k = 0; k < 3; k++) begin
        mul_q[k] <= mul_d[k];
      end
    end
    if (mv_q) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= mf_q ? ACC_W'(mul_q[k]) : acc_q[k] + ACC_W'(mul_q[k]);
      end
    end
    if (fin_q) begin
      res_pt_q  <= rnd_pt;
      res_sat_q <= |clip;
    end
  end

  assign res_o.done = done_q;
  assign res_o.sat  = res_sat_q;
  assign res_o.pt   = res_pt_q;

endmodule

// ----- tb/sv/bezier_surface_eval_test.sv -----
// Self-checking testbench for the Bezier surface evaluator: grid writes and surface evaluations.
module bezier_surface_eval_test;
  import bsev_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 64;
  localparam longint unsigned Q_ONE  = 64'd65536;
  localparam longint unsigned Q_HALF = 64'd32768;
  localparam int HEIGHT_MAP [5][5] = '{
    '{ 0,   0,   0,  0,   0},
    '{ 0,  60,  70, 40,  10},
    '{30, 200, 200, 40,  60},
    '{30,  70,  40, 50,  60},
    '{60,  40,   0, 30, 100}
  };

  typedef longint unsigned blend_t [GRID_SIZE];

  typedef struct packed {
    op_e                       op;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [Q_W-1:0]            u;
    logic [Q_W-1:0]            v;
  } surf_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      sat;
  } surf_pt_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bsev_in_if  req_if ();
  bsev_out_if res_if ();

  bezier_surface_eval u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  logic signed [COORD_W-1:0] ctrl_pts [GRID_SIZE][GRID_SIZE][3];
  surf_pt_t pending_points [$];
  int mismatches   = 0;
  int cycle_count  = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bezier_surface_eval: mismatch");
      $finish;
    end
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic blend_t bernstein_weights(logic [Q_W-1:0] t_in);
    longint unsigned t, m, binom;
    longint unsigned pt [GRID_SIZE];
    longint unsigned pm [GRID_SIZE];
    blend_t wt;
    t = 64'(t_in);
    if (t > Q_ONE) t = Q_ONE;
    m = Q_ONE - t;
    pt[0] = Q_ONE;
    pm[0] = Q_ONE;
    for (int k = 1; k < GRID_SIZE; k++) begin
      pt[k] = (pt[k-1] * t + Q_HALF) >> 16;
      pm[k] = (pm[k-1] * m + Q_HALF) >> 16;
    end
    binom = 1;
    for (int k = 0; k < GRID_SIZE; k++) begin
      if (k > 0) binom = binom * 64'(DEG - k + 1) / 64'(k);
      wt[k] = binom * ((pt[k] * pm[DEG-k] + Q_HALF) >> 16);
    end
    return wt;
  endfunction

  function automatic surf_pt_t surface_point(logic [Q_W-1:0] u, logic [Q_W-1:0] v);
    blend_t bu, bv;
    longint acc [3];
    longint unsigned w;
    longint q;
    logic signed [COORD_W-1:0] coord [3];
    surf_pt_t pt;
    bu = bernstein_weights(u);
    bv = bernstein_weights(v);
    pt.sat = 1'b0;
    for (int k = 0; k < 3; k++) acc[k] = 0;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        w = (bu[r] * bv[c] + Q_HALF) >> 16;
        for (int k = 0; k < 3; k++) begin
          acc[k] += longint'(ctrl_pts[r][c][k]) * longint'(w);
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      q = (acc[k] + 64'sd32768) >>> 16;
      if (q > longint'(COORD_MAX)) begin
        q = COORD_MAX;
        pt.sat = 1'b1;
      end
      if (q < longint'(COORD_MIN)) begin
        q = COORD_MIN;
        pt.sat = 1'b1;
      end
      coord[k] = COORD_W'(q);
    end
    pt.x = coord[0];
    pt.y = coord[1];
    pt.z = coord[2];
    return pt;
  endfunction

  function automatic void apply_request(surf_req_t rq);
    if (rq.op == OP_WRITE) begin
      if (rq.row < GRID_SIZE && rq.col < GRID_SIZE) begin
        ctrl_pts[rq.row][rq.col][0] = rq.x;
        ctrl_pts[rq.row][rq.col][1] = rq.y;
        ctrl_pts[rq.row][rq.col][2] = rq.z;
      end
    end else begin
      pending_points = {pending_points, surface_point(rq.u, rq.v)};
    end
  endfunction

  task automatic send_request(input surf_req_t rq);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.operation = rq.op;
    req_if.point_row = rq.row;
    req_if.point_col = rq.col;
    req_if.point_x   = rq.x;
    req_if.point_y   = rq.y;
    req_if.point_z   = rq.z;
    req_if.param_u   = rq.u;
    req_if.param_v   = rq.v;
    req_if.valid     = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    apply_request(rq);
  endtask

  task automatic send_write(input int r, input int c, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z);
    surf_req_t rq;
    rq.op  = OP_WRITE;
    rq.row = POS_W'(r);
    rq.col = POS_W'(c);
    rq.x   = x;
    rq.y   = y;
    rq.z   = z;
    rq.u   = Q_W'($urandom);
    rq.v   = Q_W'($urandom);
    send_request(rq);
  endtask

  task automatic send_eval(input int u, input int v);
    surf_req_t rq;
    rq.op  = OP_EVAL;
    rq.row = POS_W'($urandom);
    rq.col = POS_W'($urandom);
    rq.x   = COORD_W'($urandom);
    rq.y   = COORD_W'($urandom);
    rq.z   = COORD_W'($urandom);
    rq.u   = Q_W'(u);
    rq.v   = Q_W'(v);
    send_request(rq);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return COORD_W'(COORD_MAX);
      1:       return COORD_W'(COORD_MIN);
      2:       return COORD_W'(int'($urandom_range(2)) - 1);
      3, 4, 5: return COORD_W'(int'($urandom_range(65535)) - 32768);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] near_rail(input bit hi);
    if (hi) return COORD_W'(COORD_MAX - int'($urandom_range(63)));
    return COORD_W'(COORD_MIN + int'($urandom_range(63)));
  endfunction

  function automatic int pick_param();
    case ($urandom_range(7))
      0:       return 0;
      1:       return ONE;
      2:       return ONE + int'($urandom_range(1, ONE - 1));
      3, 4, 5: return int'($urandom_range(ONE));
      default: return int'($urandom_range((1 << Q_W) - 1));
    endcase
  endfunction

  always @(posedge clk_i) begin : check_results
    surf_pt_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_points.size() == 0) begin
        flag_mismatch("surface point with no evaluate request pending");
      end else begin
        want = pending_points.pop_front();
        if (res_if.surf_x !== want.x)
          flag_mismatch($sformatf("surf_x got %0d want %0d", res_if.surf_x, want.x));
        if (res_if.surf_y !== want.y)
          flag_mismatch($sformatf("surf_y got %0d want %0d", res_if.surf_y, want.y));
        if (res_if.surf_z !== want.z)
          flag_mismatch($sformatf("surf_z got %0d want %0d", res_if.surf_z, want.z));
        if (res_if.saturated !== want.sat)
          flag_mismatch($sformatf("saturated got %b want %b", res_if.saturated, want.sat));
      end
    end
  end

  task automatic test_reset_grid();
    send_eval(0, 0);
    send_eval(ONE, ONE);
    send_eval(0, ONE);
    send_eval(ONE, 0);
    send_eval(HALF, HALF);
    send_eval(16384, 49152);
  endtask

  task automatic test_param_clamp();
    send_eval((1 << Q_W) - 1, 0);
    send_eval(ONE + 1, (1 << Q_W) - 1);
    send_eval(70000, ONE);
  endtask

  task automatic test_point_writes();
    send_write(0, 0, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
    send_write(DEG, DEG, COORD_W'(COORD_MIN), COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
    send_write(0, DEG, -24'sd1, 24'sd0, 24'sd1);
    send_write(DEG, 0, COORD_W'(COORD_MIN), COORD_W'(COORD_MAX), 24'sd0);
    send_eval(0, 0);
    send_eval(ONE, ONE);
    send_eval(0, ONE);
    send_eval(ONE, 0);
  endtask

  task automatic test_dropped_writes();
    send_write(GRID_SIZE, 0, 24'sd1234, 24'sd1234, 24'sd1234);
    send_write(0, GRID_SIZE, 24'sd4321, 24'sd4321, 24'sd4321);
    send_write(7, 7, -24'sd77, -24'sd77, -24'sd77);
    send_write(6, 3, 24'sd63, 24'sd63, 24'sd63);
    send_eval(0, 0);
    send_eval(ONE, ONE);
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
    int sent;
    int mode;
    bit hi;
    sent = 0;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (sent < n_items) begin
      mode = $urandom_range(99);
      if (mode < 2) begin
        hi = $urandom_range(1);
        for (int r = 0; r < GRID_SIZE; r++) begin
          for (int c = 0; c < GRID_SIZE; c++) begin
            send_write(r, c, near_rail(hi), near_rail(hi), near_rail(hi));
          end
        end
        repeat (4) send_eval(pick_param(), pick_param());
        sent += GRID_SIZE * GRID_SIZE + 4;
      end else if (mode < 54) begin
        send_eval(pick_param(), pick_param());
        sent++;
      end else if (mode < 60) begin
        if ($urandom_range(1))
          send_write($urandom_range(GRID_SIZE, 7), $urandom_range(7),
                     pick_coord(), pick_coord(), pick_coord());
        else
          send_write($urandom_range(7), $urandom_range(GRID_SIZE, 7),
                     pick_coord(), pick_coord(), pick_coord());
        sent++;
      end else begin
        send_write($urandom_range(DEG), $urandom_range(DEG),
                   pick_coord(), pick_coord(), pick_coord());
        sent++;
      end
    end
  endtask

  initial begin
    req_if.valid     = 1'b0;
    req_if.operation = OP_WRITE;
    req_if.point_row = '0;
    req_if.point_col = '0;
    req_if.point_x   = '0;
    req_if.point_y   = '0;
    req_if.point_z   = '0;
    req_if.param_u   = '0;
    req_if.param_v   = '0;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        if (r < 5 && c < 5) begin
          ctrl_pts[r][c][0] = COORD_W'(25 * c * 256);
          ctrl_pts[r][c][1] = COORD_W'((100 - 25 * r) * 256);
          ctrl_pts[r][c][2] = COORD_W'(HEIGHT_MAP[r][c] * 256);
        end else begin
          for (int k = 0; k < 3; k++) ctrl_pts[r][c][k] = '0;
        end
      end
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_pct = 17;
    snk_idle_pct = 64;
    test_reset_grid();
    test_param_clamp();
    test_point_writes();
    test_dropped_writes();
    test_random_traffic(17, 64, 550);
    test_random_traffic(64, 17, 550);
    test_random_traffic(0, 0, 550);

    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("bezier_surface_eval: match");
    end else begin
      $display("bezier_surface_eval: mismatch");
    end
    $finish;
  end

endmodule
